[hdl/rmf_pkg.sv]
// shared constants, payload types and the controller state type of the running median filter
package rmf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_WIDTH   = 32;
    localparam int NUM_CELLS   = MAX_WIDTH + 1;
    localparam int IDX_BITS    = $clog2(NUM_CELLS);
    localparam int CNT_BITS    = $clog2(NUM_CELLS + 1);
    localparam int W_BITS      = 6;
    localparam int RES_BITS    = SAMPLE_BITS + 1;
    localparam int MIN_WIDTH   = 2;

    localparam logic [W_BITS-1:0]      WIDTH_RESET = W_BITS'(3);
    localparam logic [SAMPLE_BITS-1:0] SIGN_MASK   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          final_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [RES_BITS-1:0] median_x2;
        logic                       last_result;
        logic                       too_short;
    } out_item_t;

    // broadcast to every cell during one bit step of a rank selection
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] prefix;
        logic [SAMPLE_BITS-1:0] mask;
        logic [SAMPLE_BITS-1:0] bitsel;
        logic [IDX_BITS-1:0]    lo;
        logic [IDX_BITS-1:0]    hi;
    } query_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SEL,
        ST_OUT
    } state_t;

endpackage

[hdl/rmf_cell.sv]
// one history cell: holds a biased sample, shifts to its neighbor, votes in the bit search
module rmf_cell (
    input  logic                              clk,
    input  logic                              shift_en,
    input  logic [rmf_pkg::SAMPLE_BITS-1:0]   shift_in,
    input  logic [rmf_pkg::IDX_BITS-1:0]      idx,
    input  rmf_pkg::query_t                   query,
    output logic [rmf_pkg::SAMPLE_BITS-1:0]   value,
    output logic                              hit
);

    logic [rmf_pkg::SAMPLE_BITS-1:0] value_reg;
    logic                            in_window;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            value_reg <= shift_in;
        end
    end

    assign value     = value_reg;
    assign in_window = (idx >= query.lo) && (idx <= query.hi);
    // matches the prefix found so far and has a zero at the bit under test
    assign hit = in_window
              && (((value_reg ^ query.prefix) & query.mask) == '0)
              && ((value_reg & query.bitsel) == '0);

endmodule

[hdl/rmf_chain.sv]
// row of history cells with the vote count for the bit search
module rmf_chain (
    input  logic                              clk,
    input  logic                              shift_en,
    input  logic [rmf_pkg::SAMPLE_BITS-1:0]   sample_in,
    input  rmf_pkg::query_t                   query,
    output logic [rmf_pkg::CNT_BITS-1:0]      zero_count
);

    logic [rmf_pkg::SAMPLE_BITS-1:0] tap [rmf_pkg::NUM_CELLS];
    logic [rmf_pkg::NUM_CELLS-1:0]   hits;

    for (genvar i = 0; i < rmf_pkg::NUM_CELLS; i++)
    begin : g_cell
        logic [rmf_pkg::SAMPLE_BITS-1:0] link;
        if (i == 0)
        begin : g_head
            assign link = sample_in;
        end
        else
        begin : g_body
            assign link = tap[i-1];
        end
        rmf_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .shift_in (link),
            .idx      (rmf_pkg::IDX_BITS'(i)),
            .query    (query),
            .value    (tap[i]),
            .hit      (hits[i])
        );
    end

    assign zero_count = rmf_pkg::CNT_BITS'($countones(hits));

endmodule

[hdl/running_median_filter.sv]
// top level of the running median filter: controller, bit search and output register
//
// input channel data_valid / data_stall / data: one sample per transfer, final_sample
// marks the last sample of a vector. output channel res_valid / res_stall / res: one
// running median per sample, given as twice the median (odd width) or the sum of the
// upper and lower medians (even width), so the value is exact.
// cfg_we / cfg_data write the window width; it is taken up at the first sample of the
// next vector. values below 2 act as 2, above 32 as 32.
// the last 33 samples sit in a shift row of cells. each median is found by a search
// over the sample bits, msb first: in every cycle all cells in the window vote whether
// they match the prefix found so far with a zero at the tested bit.
// a result passes through an evaluation state, the bit search (one search for odd
// widths; for even widths one for the upper and one for the lower median) and the
// output state, which loads the output register. a vector start releases
// width-width/2 results at once, the final sample flushes the remaining ones. a
// vector shorter than the window yields a single result marked too_short.
// data_stall is high while a sample is being worked on. a result waits in the output
// register while res_stall is high; the search stops only when a second result is ready.
// reset clears the controller, the counters and the output valid; the width goes to 3.
module running_median_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          data_valid,
    output logic                          data_stall,
    input  rmf_pkg::in_item_t             data,
    output logic                          res_valid,
    input  logic                          res_stall,
    output rmf_pkg::out_item_t            res,
    input  logic                          cfg_we,
    input  logic [rmf_pkg::W_BITS-1:0]    cfg_data
);

    rmf_pkg::state_t state_reg, state_next;

    logic [rmf_pkg::W_BITS-1:0]      width_reg, width_next;
    logic [rmf_pkg::W_BITS-1:0]      act_w_reg, act_w_next;
    logic [rmf_pkg::W_BITS-1:0]      pend_reg, pend_next;     // results owed for this vector
    logic                            started_reg, started_next;
    logic                            early_reg, early_next;   // no result yet when sample came
    logic                            fin_reg, fin_next;
    logic                            phase_reg, phase_next;   // 0 upper median, 1 lower
    logic [rmf_pkg::SAMPLE_BITS-1:0] prefix_reg, prefix_next;
    logic [rmf_pkg::SAMPLE_BITS-1:0] mask_reg, mask_next;
    logic [rmf_pkg::SAMPLE_BITS-1:0] bitsel_reg, bitsel_next;
    logic [rmf_pkg::W_BITS-1:0]      k_reg, k_next;           // rank still sought
    logic signed [rmf_pkg::RES_BITS-1:0] acc_reg, acc_next;
    rmf_pkg::out_item_t              hold_reg, hold_next;
    logic                            res_valid_reg, res_valid_next;
    rmf_pkg::out_item_t              res_reg, res_next;

    logic                            data_accept;
    logic                            load_ok;
    logic [rmf_pkg::W_BITS-1:0]      w_clamped;
    logic [rmf_pkg::W_BITS-1:0]      half;
    logic [rmf_pkg::W_BITS-1:0]      thresh;
    logic [rmf_pkg::W_BITS-1:0]      dj;
    logic [rmf_pkg::W_BITS-1:0]      back;
    logic [rmf_pkg::W_BITS:0]        reach;
    logic [rmf_pkg::W_BITS:0]        wm1;
    logic [rmf_pkg::W_BITS:0]        oldest;
    logic [rmf_pkg::CNT_BITS-1:0]    zero_count;
    logic                            go_one;
    logic [rmf_pkg::SAMPLE_BITS-1:0] pref_step;
    logic [rmf_pkg::W_BITS-1:0]      k_step;
    logic signed [rmf_pkg::SAMPLE_BITS-1:0] median;
    rmf_pkg::query_t                 query;

    assign data_stall  = (state_reg != rmf_pkg::ST_IDLE);
    assign data_accept = data_valid && !data_stall;
    assign load_ok     = !res_valid_reg || !res_stall;
    assign res_valid   = res_valid_reg;
    assign res         = res_reg;

    // width register value brought into range
    always_comb
    begin
        if (width_reg < rmf_pkg::W_BITS'(rmf_pkg::MIN_WIDTH))
        begin
            w_clamped = rmf_pkg::W_BITS'(rmf_pkg::MIN_WIDTH);
        end
        else if (width_reg > rmf_pkg::W_BITS'(rmf_pkg::MAX_WIDTH))
        begin
            w_clamped = rmf_pkg::W_BITS'(rmf_pkg::MAX_WIDTH);
        end
        else
        begin
            w_clamped = width_reg;
        end
    end

    // window placement for the result being worked on
    assign half   = act_w_reg >> 1;
    assign thresh = fin_reg ? rmf_pkg::W_BITS'(1) : half + rmf_pkg::W_BITS'(1);
    assign dj     = pend_reg - rmf_pkg::W_BITS'(1);
    assign back   = phase_reg ? half - rmf_pkg::W_BITS'(1) : half;
    assign reach  = {1'b0, dj} + {1'b0, back};
    assign wm1    = {1'b0, act_w_reg} - (rmf_pkg::W_BITS+1)'(1);
    // at the vector start the window is pinned to the oldest samples
    assign oldest = (early_reg || (reach < wm1)) ? wm1 : reach;

    assign query.prefix = prefix_reg;
    assign query.mask   = mask_reg;
    assign query.bitsel = bitsel_reg;
    assign query.hi     = rmf_pkg::IDX_BITS'(oldest);
    assign query.lo     = rmf_pkg::IDX_BITS'(oldest - wm1);

    rmf_chain u_chain (
        .clk        (clk),
        .shift_en   (data_accept),
        .sample_in  (data.sample ^ rmf_pkg::SIGN_MASK),
        .query      (query),
        .zero_count (zero_count)
    );

    // one bit step: if the rank lies beyond the zeros, the bit is one
    assign go_one    = k_reg > rmf_pkg::W_BITS'(zero_count);
    assign pref_step = go_one ? (prefix_reg | bitsel_reg) : prefix_reg;
    assign k_step    = go_one ? k_reg - rmf_pkg::W_BITS'(zero_count) : k_reg;
    assign median    = signed'(pref_step ^ rmf_pkg::SIGN_MASK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmf_pkg::ST_IDLE;
            width_reg     <= rmf_pkg::WIDTH_RESET;
            act_w_reg     <= rmf_pkg::WIDTH_RESET;
            pend_reg      <= '0;
            started_reg   <= 1'b0;
            early_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            phase_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            act_w_reg     <= act_w_next;
            pend_reg      <= pend_next;
            started_reg   <= started_next;
            early_reg     <= early_next;
            fin_reg       <= fin_next;
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prefix_reg <= prefix_next;
        mask_reg   <= mask_next;
        bitsel_reg <= bitsel_next;
        k_reg      <= k_next;
        acc_reg    <= acc_next;
        hold_reg   <= hold_next;
        res_reg    <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        width_next     = cfg_we ? cfg_data : width_reg;
        act_w_next     = act_w_reg;
        pend_next      = pend_reg;
        started_next   = started_reg;
        early_next     = early_reg;
        fin_next       = fin_reg;
        phase_next     = phase_reg;
        prefix_next    = prefix_reg;
        mask_next      = mask_reg;
        bitsel_next    = bitsel_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        hold_next      = hold_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;

        case (state_reg)
            rmf_pkg::ST_IDLE:
            begin
                if (data_accept)
                begin
                    pend_next  = pend_reg + rmf_pkg::W_BITS'(1);
                    fin_next   = data.final_sample;
                    early_next = !started_reg;
                    if ((pend_reg == '0) && !started_reg)
                    begin
                        act_w_next = w_clamped;
                    end
                    state_next = rmf_pkg::ST_EVAL;
                end
            end

            rmf_pkg::ST_EVAL:
            begin
                if (!started_reg && (pend_reg < act_w_reg))
                begin
                    // window not yet full
                    if (fin_reg)
                    begin
                        hold_next.median_x2   = '0;
                        hold_next.last_result = 1'b1;
                        hold_next.too_short   = 1'b1;
                        state_next            = rmf_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = rmf_pkg::ST_IDLE;
                    end
                end
                else if (pend_reg >= thresh)
                begin
                    phase_next  = 1'b0;
                    prefix_next = '0;
                    mask_next   = '0;
                    bitsel_next = rmf_pkg::SIGN_MASK;
                    k_next      = half + rmf_pkg::W_BITS'(1);
                    state_next  = rmf_pkg::ST_SEL;
                end
                else
                begin
                    state_next = rmf_pkg::ST_IDLE;
                end
            end

            rmf_pkg::ST_SEL:
            begin
                prefix_next = pref_step;
                k_next      = k_step;
                mask_next   = mask_reg | bitsel_reg;
                bitsel_next = bitsel_reg >> 1;
                if (bitsel_reg[0])
                begin
                    if (!act_w_reg[0] && !phase_reg)
                    begin
                        // upper median done, now the lower one
                        acc_next    = rmf_pkg::RES_BITS'(median);
                        phase_next  = 1'b1;
                        prefix_next = '0;
                        mask_next   = '0;
                        bitsel_next = rmf_pkg::SIGN_MASK;
                        k_next      = half;
                    end
                    else
                    begin
                        if (act_w_reg[0])
                        begin
                            hold_next.median_x2 = {median, 1'b0};
                        end
                        else
                        begin
                            hold_next.median_x2 = acc_reg + rmf_pkg::RES_BITS'(median);
                        end
                        hold_next.last_result = fin_reg && (pend_reg == rmf_pkg::W_BITS'(1));
                        hold_next.too_short   = 1'b0;
                        state_next            = rmf_pkg::ST_OUT;
                    end
                end
            end

            rmf_pkg::ST_OUT:
            begin
                if (load_ok)
                begin
                    res_next       = hold_reg;
                    res_valid_next = 1'b1;
                    if (hold_reg.last_result)
                    begin
                        // end of vector
                        pend_next    = '0;
                        started_next = 1'b0;
                        state_next   = rmf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pend_next    = pend_reg - rmf_pkg::W_BITS'(1);
                        started_next = 1'b1;
                        state_next   = rmf_pkg::ST_EVAL;
                    end
                end
            end

            default:
            begin
                state_next = rmf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/rmf_checker.sv]
// port checks for the running median filter, bound to the top level
module rmf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          data_valid,
    input logic                          data_stall,
    input logic                          res_valid,
    input logic                          res_stall,
    input rmf_pkg::out_item_t            res
);

    // no result shows while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // a stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

    // a short-vector result ends the vector and carries a zero median
    a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.too_short |-> res.last_result && (res.median_x2 == '0))
        else $error("short-vector result malformed");

    // a sample transfer is followed by a stalled input
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        data_valid && !data_stall |=> data_stall)
        else $error("input not stalled after a sample transfer");

endmodule

bind running_median_filter rmf_checker u_rmf_checker (.*);

[dv/rmf_checker.sv]
// checker for the running median filter: predicts the medians of each transfer and compares
module rmf_tb_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           data_valid,
    input  logic                           data_stall,
    input  rmf_pkg::in_item_t              data,
    input  logic                           res_valid,
    input  logic                           res_stall,
    input  rmf_pkg::out_item_t             res,
    input  logic                           cfg_we,
    input  logic [rmf_pkg::W_BITS-1:0]     cfg_data,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [rmf_pkg::SAMPLE_BITS-1:0] hist [rmf_pkg::NUM_CELLS];
    logic [15:0]                 seen_cnt;
    logic [15:0]                 given_cnt;
    logic [rmf_pkg::W_BITS-1:0]  width_reg;
    int                          active_w;
    bit                          started;
    rmf_pkg::out_item_t          expected_medians[$];

    // k-th smallest of w samples starting at offset oldest, going newer
    function automatic int kth_smallest(int oldest, int w, int k);
        int vals [rmf_pkg::MAX_WIDTH];
        int i;
        int a;
        int t;
        int idx;
        for (i = 0; i < w; i++)
        begin
            idx = oldest - i;
            vals[i] = (idx >= 0 && idx < rmf_pkg::NUM_CELLS) ? int'(hist[idx]) : 0;
        end
        for (i = 1; i < w; i++)
        begin
            t = vals[i];
            a = i - 1;
            while (a >= 0 && vals[a] > t)
            begin
                vals[a + 1] = vals[a];
                a--;
            end
            vals[a + 1] = t;
        end
        return vals[k - 1];
    endfunction

    // window slid inward near the vector ends
    function automatic int oldest_offset(int dj, int back, int w, bit early, int count);
        int o;
        o = dj + back;
        if (early && o > count - 1)
            o = count - 1;
        else if (o < w - 1)
            o = w - 1;
        return o;
    endfunction

    function automatic int median_sum(int dj, int w, bit early, int count);
        int h;
        h = w / 2;
        if (w % 2)
            return 2 * kth_smallest(oldest_offset(dj, h, w, early, count), w, h + 1);
        return kth_smallest(oldest_offset(dj, h, w, early, count), w, h + 1)
             + kth_smallest(oldest_offset(dj, h - 1, w, early, count), w, h);
    endfunction

    function automatic void predict_medians(rmf_pkg::in_item_t it);
        int                 w;
        int                 p;
        int                 thresh;
        int                 n;
        bit                 early;
        rmf_pkg::out_item_t r;
        if (seen_cnt == 0 && !started)
            active_w = (width_reg < rmf_pkg::MIN_WIDTH) ? rmf_pkg::MIN_WIDTH :
                       (width_reg > rmf_pkg::MAX_WIDTH) ? rmf_pkg::MAX_WIDTH :
                       int'(width_reg);
        w = active_w;
        for (int i = rmf_pkg::NUM_CELLS - 1; i > 0; i--)
            hist[i] = hist[i - 1];
        hist[0] = it.sample;
        seen_cnt = seen_cnt + 16'd1;
        early = !started;
        if (early && seen_cnt < w)
        begin
            if (it.final_sample)
            begin
                r = '{median_x2: '0, last_result: 1'b1, too_short: 1'b1};
                expected_medians.push_back(r);
                seen_cnt = '0;
                given_cnt = '0;
                started = 0;
            end
            return;
        end
        p = int'(16'(seen_cnt - given_cnt));
        thresh = it.final_sample ? 1 : w / 2 + 1;
        n = 0;
        while (p >= thresh && n < rmf_pkg::MAX_WIDTH)
        begin
            r.median_x2 = rmf_pkg::RES_BITS'(median_sum(p - 1, w, early, int'(seen_cnt)));
            r.last_result = it.final_sample && p == 1;
            r.too_short = 1'b0;
            expected_medians.push_back(r);
            n++;
            p--;
            given_cnt = given_cnt + 16'd1;
            started = 1;
        end
        if (it.final_sample)
        begin
            if (n > 0)
                expected_medians[$].last_result = 1'b1;
            seen_cnt = '0;
            given_cnt = '0;
            started = 0;
        end
    endfunction

    assign pending = expected_medians.size();

    always @(posedge clk or negedge rst_n)
    begin
        rmf_pkg::out_item_t exp_r;
        if (!rst_n)
        begin
            seen_cnt = '0;
            given_cnt = '0;
            width_reg = rmf_pkg::WIDTH_RESET;
            active_w = int'(rmf_pkg::WIDTH_RESET);
            started = 0;
            expected_medians.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
                width_reg = cfg_data;
            if (data_valid && !data_stall)
                predict_medians(data);
            if (res_valid && !res_stall)
            begin
                if (expected_medians.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: %0d last %0b short %0b",
                                 res.median_x2, res.last_result, res.too_short);
                end
                else
                begin
                    exp_r = expected_medians.pop_front();
                    if (res !== exp_r)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     exp_r.median_x2, exp_r.last_result, exp_r.too_short,
                                     res.median_x2, res.last_result, res.too_short);
                    end
                end
            end
        end
    end

endmodule

[dv/tb_running_median_filter.sv]
// testbench top of the running median filter: stimulus, idling and verdict
module tb_running_median_filter;
    timeunit 1ns;
    timeprecision 1ps;

    logic                       clk = 0;
    logic                       rst_n;
    logic                       data_valid = 0;
    logic                       data_stall;
    rmf_pkg::in_item_t          data = '0;
    logic                       res_valid;
    logic                       res_stall = 0;
    rmf_pkg::out_item_t         res;
    logic                       cfg_we = 0;
    logic [rmf_pkg::W_BITS-1:0] cfg_data = '0;
    int                         fail_count;
    int                         pending;
    int                         tx_idle = 0;     // percent of cycles the sender holds off
    int                         rx_idle = 0;     // percent of cycles the receiver stalls
    int                         sent = 0;
    longint                     cycles = 0;

    running_median_filter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data       (data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    rmf_tb_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data       (data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
        res_stall <= rst_n && ($urandom_range(0, 99) < rx_idle);

    // watchdog: fails the run if it goes on too long; even widths need two searches per result
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one sample transfer; valid stays high across back-to-back transfers
    task automatic send_sample(logic signed [rmf_pkg::SAMPLE_BITS-1:0] s, logic fin);
        if ($urandom_range(0, 99) < tx_idle)
        begin
            data_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle);
        end
        data_valid <= 1'b1;
        data <= '{sample: s, final_sample: fin};
        do
            @(posedge clk);
        while (data_stall);
        sent++;
    endtask

    // mode 0: full range, 1: few distinct values so ties are common
    task automatic send_vector(int len, int mode);
        logic signed [rmf_pkg::SAMPLE_BITS-1:0] s;
        for (int i = 0; i < len; i++)
        begin
            s = (mode == 0) ? rmf_pkg::SAMPLE_BITS'($urandom)
                            : rmf_pkg::SAMPLE_BITS'($urandom_range(0, 6) - 3);
            send_sample(s, i == len - 1);
        end
    endtask

    // hold off until every result is in and the block has settled, then write the width
    task automatic write_width(logic [rmf_pkg::W_BITS-1:0] w);
        data_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int w;
        int eff;
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset width 3, extremes, too-short vectors, exact-width vector
        send_sample(16'sh7fff, 1'b0);
        send_sample(-16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(-16'sh0001, 1'b0);
        send_sample(16'sh5555, 1'b1);
        send_sample(16'sh2aaa, 1'b1);              // single sample, too short
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh7fff, 1'b1);              // two samples, too short
        send_vector(3, 0);                         // exactly one window
        write_width(6'd0);                         // below range acts as 2
        send_sample(-16'sh8000, 1'b0);
        send_sample(-16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b1);
        send_sample(16'sh1234, 1'b1);              // too short at width 2
        write_width(6'd63);                        // above range acts as 32
        send_vector(33, 0);
        write_width(6'd4);
        send_vector(4, 0);

        // random phases: sender idles lightly, then receiver, then neither
        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle = (ph == 0) ? 7 : (ph == 1) ? 69 : 0;
            rx_idle = (ph == 0) ? 69 : (ph == 1) ? 7 : 0;
            for (int k = 0; k < 5; k++)
            begin
                case (k)
                    0: w = 2;
                    1: w = 32;
                    2: w = 1;
                    default: w = $urandom_range(3, 9);
                endcase
                if (ph == 2 && k == 1)
                    w = 33;
                write_width(rmf_pkg::W_BITS'(w));
                eff = (w < rmf_pkg::MIN_WIDTH) ? rmf_pkg::MIN_WIDTH :
                      (w > rmf_pkg::MAX_WIDTH) ? rmf_pkg::MAX_WIDTH : w;
                repeat ((eff > 16) ? 1 : 2)
                    send_vector($urandom_range(1, eff + ((eff > 16) ? 3 : 8)),
                                $urandom_range(0, 3) == 0);
            end
        end
        // top up toward the item count at small widths
        write_width(6'd5);
        while (sent < 280)
            send_vector($urandom_range(1, 12), $urandom_range(0, 1));

        data_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
hdl/rmf_pkg.sv
hdl/rmf_cell.sv
hdl/rmf_chain.sv
hdl/running_median_filter.sv
hdl/rmf_checker.sv
dv/rmf_checker.sv
dv/tb_running_median_filter.sv
